// ===== sv/assert_macros.svh =====
// Assertion macros shared by the hash pipeline RTL.
// Has no dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define JMBH_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("jmbh assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define JMBH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("jmbh assertion failed");

`endif

// ===== sv/jmbh_pkg.sv =====
// Types, constants and per-stage functions of the mix and bucket hash pipeline.
// No dependencies; used by jenkins_mix_bucket_hash.
package jmbh_pkg;

   localparam int WORD_W     = 32;
   localparam int MIX_ROUNDS = 9;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [3:0]        round_idx_type;
   typedef logic [4:0]        shift_type;

   typedef enum logic [1:0] {
      TGT_W0,
      TGT_W1,
      TGT_W2
   } mix_target_type;

   localparam shift_type MIX_SHIFT [MIX_ROUNDS] = '{
      5'd13, 5'd8, 5'd13, 5'd12, 5'd16, 5'd5, 5'd3, 5'd10, 5'd15
   };

   localparam mix_target_type MIX_TARGET [MIX_ROUNDS] = '{
      TGT_W0, TGT_W1, TGT_W2, TGT_W0, TGT_W1, TGT_W2, TGT_W0, TGT_W1, TGT_W2
   };

   typedef struct packed {
      word_type w0;
      word_type w1;
      word_type w2;
      word_type size;
      logic     err;
   } mix_stage_type;

   typedef struct packed {
      word_type rem;
      word_type dvd;
      word_type size;
      logic     err;
   } div_stage_type;

   typedef struct packed {
      word_type bucket;
      logic     size_error;
   } result_type;

   // One subtract, subtract, xor-shift round of the 96-bit mix.
   function automatic mix_stage_type mix_round(input round_idx_type r,
                                               input mix_stage_type s);
      mix_stage_type o;
      o = s;
      unique case (MIX_TARGET[r])
         TGT_W0: begin
            o.w0 = (s.w0 - s.w1 - s.w2) ^ (s.w2 >> MIX_SHIFT[r]);
         end
         TGT_W1: begin
            o.w1 = (s.w1 - s.w2 - s.w0) ^ (s.w0 << MIX_SHIFT[r]);
         end
         TGT_W2: begin
            o.w2 = (s.w2 - s.w0 - s.w1) ^ (s.w1 >> MIX_SHIFT[r]);
         end
         default: begin
            o = s;
         end
      endcase
      return o;
   endfunction

   // One restoring step of the remainder: brings in the next dividend bit.
   function automatic div_stage_type div_step(input div_stage_type s);
      div_stage_type      o;
      logic [WORD_W:0]    trial;
      logic [WORD_W:0]    diff;
      o     = s;
      trial = {s.rem, s.dvd[WORD_W-1]};
      diff  = trial - {1'b0, s.size};
      if (trial >= {1'b0, s.size}) begin
         o.rem = diff[WORD_W-1:0];
      end else begin
         o.rem = trial[WORD_W-1:0];
      end
      o.dvd = {s.dvd[WORD_W-2:0], 1'b0};
      return o;
   endfunction

endpackage

// ===== sv/jenkins_mix_bucket_hash.sv =====
// Channel   Direction  Signals
// req       in         req_valid, req_ready, req_seed, req_key_item, req_table_size
// rsp       out        rsp_valid, rsp_ready, rsp_bucket, rsp_size_error
//
// One transfer is accepted per cycle while the skid register is empty. Each request passes
// nine mix-round stages, thirty-two remainder stages and one output register in order.
// The remainder stages are restoring steps, one quotient bit per stage.
// Reset clears all valid bits; the payload registers are not reset.
// A skid register behind the output register absorbs one result when rsp stalls.
// While it is full, the pipeline and req_ready stall. Depends on jmbh_pkg and assert_macros.svh.
`include "assert_macros.svh"

module jenkins_mix_bucket_hash (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [31:0]             req_seed,
   input  logic [31:0]             req_key_item,
   input  logic [31:0]             req_table_size,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [31:0]             rsp_bucket,
   output logic                    rsp_size_error
);

   localparam int NumStages = jmbh_pkg::MIX_ROUNDS + jmbh_pkg::WORD_W;

   logic [NumStages-1:0]    v_ff;
   logic [NumStages-1:0]    v_in;
   logic                    en;

   jmbh_pkg::mix_stage_type mix_first;
   jmbh_pkg::mix_stage_type mix_in [jmbh_pkg::MIX_ROUNDS];
   jmbh_pkg::mix_stage_type mix_ff [jmbh_pkg::MIX_ROUNDS];
   jmbh_pkg::div_stage_type div_first;
   jmbh_pkg::div_stage_type div_in [jmbh_pkg::WORD_W];
   jmbh_pkg::div_stage_type div_ff [jmbh_pkg::WORD_W];

   jmbh_pkg::result_type    pipe_res;
   logic                    pipe_out_v;
   logic                    take;
   logic                    out_v_ff;
   logic                    out_v_in;
   jmbh_pkg::result_type    out_ff;
   logic                    skid_v_ff;
   logic                    skid_v_in;
   jmbh_pkg::result_type    skid_ff;
   logic                    load_out_skid;
   logic                    load_out_pipe;
   logic                    load_skid;

   assign en        = !skid_v_ff;
   assign req_ready = en;
   assign v_in      = {v_ff[NumStages-2:0], req_valid};

   always_comb begin
      mix_first.w0   = req_seed;
      mix_first.w1   = '0;
      mix_first.w2   = req_key_item;
      mix_first.size = req_table_size;
      mix_first.err  = (req_table_size == '0);
   end

   for (genvar k = 0; k < jmbh_pkg::MIX_ROUNDS; k++) begin : g_mix
      if (k == 0) begin : g_head
         assign mix_in[k] = jmbh_pkg::mix_round(jmbh_pkg::round_idx_type'(k), mix_first);
      end else begin : g_body
         assign mix_in[k] = jmbh_pkg::mix_round(jmbh_pkg::round_idx_type'(k), mix_ff[k-1]);
      end
   end

   always_comb begin
      div_first.rem  = '0;
      div_first.dvd  = mix_ff[jmbh_pkg::MIX_ROUNDS-1].w2;
      div_first.size = mix_ff[jmbh_pkg::MIX_ROUNDS-1].size;
      div_first.err  = mix_ff[jmbh_pkg::MIX_ROUNDS-1].err;
   end

   for (genvar j = 0; j < jmbh_pkg::WORD_W; j++) begin : g_div
      if (j == 0) begin : g_head
         assign div_in[j] = jmbh_pkg::div_step(div_first);
      end else begin : g_body
         assign div_in[j] = jmbh_pkg::div_step(div_ff[j-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < jmbh_pkg::MIX_ROUNDS; k++) begin
            mix_ff[k] <= mix_in[k];
         end
         for (int j = 0; j < jmbh_pkg::WORD_W; j++) begin
            div_ff[j] <= div_in[j];
         end
      end
   end

   always_comb begin
      pipe_res.size_error = div_ff[jmbh_pkg::WORD_W-1].err;
      pipe_res.bucket     = div_ff[jmbh_pkg::WORD_W-1].err ? '0
                                                          : div_ff[jmbh_pkg::WORD_W-1].rem;
   end

   assign pipe_out_v = en && v_ff[NumStages-1];
   assign take       = !out_v_ff || rsp_ready;

   always_comb begin
      out_v_in      = out_v_ff;
      skid_v_in     = skid_v_ff;
      load_out_skid = 1'b0;
      load_out_pipe = 1'b0;
      load_skid     = 1'b0;
      if (take) begin
         if (skid_v_ff) begin
            out_v_in      = 1'b1;
            skid_v_in     = 1'b0;
            load_out_skid = 1'b1;
         end else begin
            out_v_in      = pipe_out_v;
            load_out_pipe = pipe_out_v;
         end
      end else if (pipe_out_v) begin
         skid_v_in = 1'b1;
         load_skid = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_skid) begin
         skid_ff <= pipe_res;
      end
      if (load_out_skid) begin
         out_ff <= skid_ff;
      end else if (load_out_pipe) begin
         out_ff <= pipe_res;
      end
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_bucket     = out_ff.bucket;
   assign rsp_size_error = out_ff.size_error;

   `JMBH_ASSERT_SAME(a_skid_behind_out, clock, reset, skid_v_ff, out_v_ff)
   `JMBH_ASSERT_SAME(a_err_bucket_zero, clock, reset,
                     rsp_valid && rsp_size_error, rsp_bucket == '0)
   `JMBH_ASSERT_NEXT(a_stall_fills_skid, clock, reset,
                     out_v_ff && !rsp_ready && pipe_out_v, skid_v_ff && !req_ready)

endmodule

// ===== sim/jmbh_bucket_checker.sv =====
// Checker for the mix and bucket hash block: predicts each bucket from the request
// transfers and compares it with the response transfers. Depends on jmbh_pkg.
`timescale 1ns / 1ps

module jmbh_bucket_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [31:0] req_seed,
   input  logic [31:0] req_key_item,
   input  logic [31:0] req_table_size,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_bucket,
   input  logic        rsp_size_error,
   output int          outstanding,
   output int          mismatches
);

   jmbh_pkg::result_type expected_buckets [$];
   int                   err_count;
   int                   checked_count;

   assign mismatches = err_count;

   function automatic jmbh_pkg::result_type predict_bucket(
      input jmbh_pkg::word_type seed,
      input jmbh_pkg::word_type key_item,
      input jmbh_pkg::word_type table_size);
      jmbh_pkg::word_type   a;
      jmbh_pkg::word_type   b;
      jmbh_pkg::word_type   c;
      jmbh_pkg::result_type r;
      a = seed;
      b = '0;
      c = key_item;
      a = (a - b - c) ^ (c >> 13);
      b = (b - c - a) ^ (a << 8);
      c = (c - a - b) ^ (b >> 13);
      a = (a - b - c) ^ (c >> 12);
      b = (b - c - a) ^ (a << 16);
      c = (c - a - b) ^ (b >> 5);
      a = (a - b - c) ^ (c >> 3);
      b = (b - c - a) ^ (a << 10);
      c = (c - a - b) ^ (b >> 15);
      if (table_size == '0) begin
         r.bucket     = '0;
         r.size_error = 1'b1;
      end else begin
         r.bucket     = c % table_size;
         r.size_error = 1'b0;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      err_count++;
   endtask

   always @(posedge clock) begin
      jmbh_pkg::result_type want;
      if (reset) begin
         expected_buckets.delete();
         outstanding <= 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_buckets.push_back(predict_bucket(req_seed, req_key_item,
                                                      req_table_size));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_buckets.size() == 0) begin
               report_mismatch($sformatf("unexpected result bucket=%08h size_error=%0b",
                                         rsp_bucket, rsp_size_error));
            end else begin
               want = expected_buckets.pop_front();
               checked_count++;
               if (rsp_bucket !== want.bucket) begin
                  report_mismatch($sformatf("result %0d bucket got %08h want %08h",
                                            checked_count, rsp_bucket, want.bucket));
               end
               if (rsp_size_error !== want.size_error) begin
                  report_mismatch($sformatf("result %0d size_error got %0b want %0b",
                                            checked_count, rsp_size_error,
                                            want.size_error));
               end
            end
         end
         outstanding <= expected_buckets.size();
      end
   end

endmodule

// ===== sim/testbench.sv =====
// Top of the bucket hash testbench: clock, reset, request stimulus, response
// back-pressure and the verdict. Depends on jmbh_pkg and jmbh_bucket_checker.
`timescale 1ns / 1ps

module testbench;

   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 60;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_seed = '0;
   logic [31:0] req_key_item = '0;
   logic [31:0] req_table_size = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_bucket;
   logic        rsp_size_error;

   int outstanding;
   int mismatches;
   int sender_idle_pct = 0;
   int recv_stall_pct = 0;
   int quiet_cycles = 0;
   int hold_left = 0;
   logic hold_go = 1'b0;
   logic hold_done = 1'b0;
   int items_sent = 0;
   int zero_sizes = 0;
   int unit_sizes = 0;

   jenkins_mix_bucket_hash uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_seed       (req_seed),
      .req_key_item   (req_key_item),
      .req_table_size (req_table_size),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_bucket     (rsp_bucket),
      .rsp_size_error (rsp_size_error)
   );

   jmbh_bucket_checker bucket_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_seed       (req_seed),
      .req_key_item   (req_key_item),
      .req_table_size (req_table_size),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_bucket     (rsp_bucket),
      .rsp_size_error (rsp_size_error),
      .outstanding    (outstanding),
      .mismatches     (mismatches)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // The receiver; a single long hold-off is counted here once requested.
   always @(posedge clock) begin
      if (hold_go && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Timeout: no transfer for %0d cycles", quiet_cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic jmbh_pkg::word_type pick_word();
      case ($urandom_range(15))
         0: return '0;
         1: return '1;
         default: return $urandom();
      endcase
   endfunction

   function automatic jmbh_pkg::word_type pick_size();
      case ($urandom_range(9))
         0: return '0;
         1: return 32'd1;
         2: return $urandom_range(16, 2);
         3: return 32'd1 << $urandom_range(31);
         4: return 32'hFFFF_FFFF - $urandom_range(15);
         default: return $urandom();
      endcase
   endfunction

   task automatic set_idling(input int sender_pct, input int recv_pct);
      sender_idle_pct <= sender_pct;
      recv_stall_pct  <= recv_pct;
   endtask

   task automatic send_item(input jmbh_pkg::word_type seed,
                            input jmbh_pkg::word_type key_item,
                            input jmbh_pkg::word_type table_size);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_seed       <= seed;
      req_key_item   <= key_item;
      req_table_size <= table_size;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      if (table_size == '0) zero_sizes++;
      if (table_size == 32'd1) unit_sizes++;
   endtask

   task automatic send_random(input int count);
      repeat (count) send_item(pick_word(), pick_word(), pick_size());
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes, zero size, size of one, power-of-two sizes, other small and large sizes.
      send_item(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
      send_item(32'h0000_0000, 32'h0000_0000, 32'h0000_0001);
      send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001);
      send_item(32'h1234_5678, 32'h9ABC_DEF0, 32'h0000_0001);
      send_item(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
      send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
      send_item(32'h0000_0000, 32'h0000_0000, 32'h8000_0000);
      send_item(32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h8000_0001);
      send_item(32'h5A5A_5A5A, 32'hA5A5_A5A5, 32'h0000_0002);
      send_item(32'h0000_0001, 32'h0000_0001, 32'h0000_0003);
      send_item(32'h8000_0000, 32'h8000_0000, 32'h0000_0007);
      send_item(32'hDEAD_BEEF, 32'h0BAD_F00D, 32'h0001_0000);
      send_item(32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF);
      send_item(32'hFFFF_FFFE, 32'h7FFF_FFFF, 32'h0000_0400);
      send_item(32'hCAFE_BABE, 32'h0000_0000, 32'h0000_0000);
      send_item(32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h0000_03E8);

      set_idling(0, 0);
      send_random(400);
      set_idling(68, 0);
      send_random(350);
      set_idling(0, 68);
      send_random(350);
      set_idling(26, 26);
      send_random(350);

      // Back-pressure: the receiver holds off while the sender keeps offering.
      set_idling(0, 0);
      hold_go <= 1'b1;
      send_random(200);
      wait_drained();
      set_idling(26, 26);
      send_random(50);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d transfers (%0d with zero size, %0d with size one)",
               items_sent, zero_sizes, unit_sizes);
      $display("Idling phases: none, sender, receiver, both, long receiver hold-off");
      if (mismatches == 0 && outstanding == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, outstanding);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
